### hdl/bsm_pkg.sv
package bsm_pkg;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 9;

    localparam logic [7:0] OP_PUSH  = 8'd0;
    localparam logic [7:0] OP_ADD   = 8'd1;
    localparam logic [7:0] OP_SUB   = 8'd2;
    localparam logic [7:0] OP_MUL   = 8'd3;
    localparam logic [7:0] OP_SHOW  = 8'd4;
    localparam logic [7:0] OP_HALT  = 8'd5;
    localparam logic [7:0] OP_NOP   = 8'd6;

    typedef enum logic [2:0] {
        ST_EXEC    = 3'd0,
        ST_AWAIT   = 3'd1,
        ST_HALT    = 3'd2,
        ST_UNDER   = 3'd3,
        ST_OVER    = 3'd4,
        ST_UNKNOWN = 3'd5,
        ST_MISSING = 3'd6,
        ST_IGNORED = 3'd7
    } status_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       start_req;
        logic       last_byte;
    } code_item_t;

    typedef struct packed {
        status_t                    status;
        logic                       print_valid;
        logic signed [DATA_W-1:0]   print_value;
        logic [DEPTH_W-1:0]         depth;
    } result_item_t;

endpackage

### hdl/bsm_stack_ram.sv
module bsm_stack_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [bsm_pkg::DATA_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [bsm_pkg::DATA_W-1:0] rd_data
);
    import bsm_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write-first: a spill to the entry being fetched is forwarded
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/bsm_exec.sv
module bsm_exec #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  bsm_pkg::code_item_t   item,
    output bsm_pkg::result_item_t res
);
    import bsm_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // top two entries live in registers; the RAM holds the rest
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic [DATA_W-1:0] nos_reg, nos_next;
    logic              expect_reg, expect_next;
    logic              stopped_reg, stopped_next;

    logic [CW-1:0]     eff_count;
    logic              eff_expect;
    logic              eff_stopped;
    logic [CW-1:0]     count_m2;
    logic [CW-1:0]     next_m3;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] below;
    logic              wr_en;
    status_t           status;
    logic              pvalid;

    assign eff_count   = item.start_req ? '0 : count_reg;
    assign eff_expect  = item.start_req ? 1'b0 : expect_reg;
    assign eff_stopped = item.start_req ? 1'b0 : stopped_reg;
    assign count_m2    = eff_count - CW'(2);
    assign next_m3     = count_next - CW'(3);

    always_comb
    begin
        case (item.code_byte)
            OP_ADD:  alu_res = nos_reg + tos_reg;
            OP_SUB:  alu_res = nos_reg - tos_reg;
            default: alu_res = nos_reg * tos_reg;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        tos_next     = tos_reg;
        nos_next     = nos_reg;
        expect_next  = expect_reg;
        stopped_next = stopped_reg;
        wr_en        = 1'b0;
        status       = ST_EXEC;
        pvalid       = 1'b0;
        if (accept)
        begin
            count_next   = eff_count;
            expect_next  = eff_expect;
            stopped_next = eff_stopped;
            if (eff_stopped)
            begin
                status = ST_IGNORED;
            end
            else if (eff_expect)
            begin
                expect_next = 1'b0;
                if (eff_count >= CW'(STACK_DEPTH))
                begin
                    status       = ST_OVER;
                    stopped_next = 1'b1;
                end
                else
                begin
                    // old next-of-stack spills to RAM
                    wr_en      = (eff_count >= CW'(2));
                    tos_next   = {{(DATA_W-8){1'b0}}, item.code_byte};
                    nos_next   = tos_reg;
                    count_next = eff_count + CW'(1);
                end
            end
            else
            begin
                unique case (item.code_byte) inside
                    OP_PUSH:
                    begin
                        if (item.last_byte)
                        begin
                            status       = ST_MISSING;
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            status      = ST_AWAIT;
                            expect_next = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL:
                    begin
                        if (eff_count < CW'(2))
                        begin
                            status       = ST_UNDER;
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            tos_next   = alu_res;
                            nos_next   = below;
                            count_next = eff_count - CW'(1);
                        end
                    end
                    OP_SHOW:
                    begin
                        if (eff_count == '0)
                        begin
                            status       = ST_UNDER;
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            pvalid = 1'b1;
                        end
                    end
                    OP_HALT:
                    begin
                        status       = ST_HALT;
                        stopped_next = 1'b1;
                    end
                    OP_NOP:
                    begin
                        status = ST_EXEC;
                    end
                    default:
                    begin
                        status       = ST_UNKNOWN;
                        stopped_next = 1'b1;
                    end
                endcase
            end
            if (item.last_byte)
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.status      = status;
        res.print_valid = pvalid;
        res.print_value = pvalid ? signed'(tos_reg) : '0;
        res.depth       = DEPTH_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            expect_reg  <= 1'b0;
            stopped_reg <= 1'b1;
        end
        else
        begin
            count_reg   <= count_next;
            expect_reg  <= expect_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        nos_reg <= nos_next;
    end

    // fetch the third entry of the next state ahead of time
    bsm_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_m2[AW-1:0]),
        .wr_data (nos_reg),
        .rd_addr (next_m3[AW-1:0]),
        .rd_data (below)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_expect_running: assert property (@(posedge clk) disable iff (!rst_n)
        expect_reg |-> !stopped_reg)
        else $error("awaiting immediate while stopped");

    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last_byte |=> stopped_reg)
        else $error("last item did not stop the run");

    a_print_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.print_valid |-> res.status == ST_EXEC)
        else $error("print with non-executed status");
`endif

endmodule

### hdl/bsm_out_buf.sv
module bsm_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  bsm_pkg::result_item_t load_item,
    output logic                  full,
    output logic                  result_valid,
    input  logic                  result_stall,
    output bsm_pkg::result_item_t result_item
);
    import bsm_pkg::*;

    logic         main_valid_reg;
    logic         skid_valid_reg;
    result_item_t main_reg;
    result_item_t skid_reg;
    logic         take;

    assign take         = main_valid_reg && !result_stall;
    assign full         = skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result_item  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || take)
        begin
            main_valid_reg <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || take)
        begin
            main_reg <= skid_valid_reg ? skid_reg : load_item;
        end
        else if (load)
        begin
            skid_reg <= load_item;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid item without a head item");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        load && main_valid_reg && result_stall |=> skid_valid_reg)
        else $error("item lost while output stalled");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !result_stall |=> main_valid_reg && !skid_valid_reg)
        else $error("skid item not moved up");
`endif

endmodule

### hdl/bytecode_stack_machine_unit.sv
// Channel   Direction  Handshake                  Payload
// code      in         code_valid / code_stall     code_item   (bsm_pkg::code_item_t)
// result    out        result_valid / result_stall result_item (bsm_pkg::result_item_t)
//
// One item per cycle while code_stall is low; its result is registered in the output buffer.
// Top two stack entries are held in registers, the third is prefetched from the stack RAM.
// Reset clears the stack count and leaves the machine stopped until an item with start_req.
// A two-entry output buffer keeps code_stall low while one result waits under result_stall.
module bytecode_stack_machine_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  code_valid,
    output logic                  code_stall,
    input  bsm_pkg::code_item_t   code_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output bsm_pkg::result_item_t result_item
);
    import bsm_pkg::*;

    logic         accept;
    result_item_t exec_res;

    assign accept = code_valid && !code_stall;

    bsm_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (code_item),
        .res    (exec_res)
    );

    bsm_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .load_item    (exec_res),
        .full         (code_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

### sim/bytecode_stack_machine_unit_tb.sv
`timescale 1ns / 1ps

module bytecode_stack_machine_unit_tb;

    import bsm_pkg::*;

    localparam int STACK_DEPTH = 256;

    typedef struct {
        code_item_t item;
        bit         drain;
    } backlog_entry_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         code_valid   = 1'b0;
    logic         code_stall;
    code_item_t   code_item    = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;

    bytecode_stack_machine_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_valid  (code_valid),
        .code_stall  (code_stall),
        .code_item   (code_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_item (result_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // machine state as the byte stream should leave it
    logic [31:0] mach_stack [STACK_DEPTH];
    int          mach_count   = 0;
    bit          mach_await   = 1'b0;
    bit          mach_stopped = 1'b1;

    backlog_entry_t code_backlog [$];
    result_item_t   due_results [$];
    backlog_entry_t next_entry;
    result_item_t   want;
    int             items_queued   = 0;
    int             mismatch_count = 0;
    bit             prog_first     = 1'b0;

    function automatic result_item_t run_byte(code_item_t it);
        result_item_t r;
        logic [31:0]  a;
        logic [31:0]  b;
        r.status      = ST_EXEC;
        r.print_valid = 1'b0;
        r.print_value = '0;
        if (it.start_req)
        begin
            mach_count   = 0;
            mach_await   = 1'b0;
            mach_stopped = 1'b0;
        end
        if (mach_stopped)
            r.status = ST_IGNORED;
        else if (mach_await)
        begin
            mach_await = 1'b0;
            if (mach_count >= STACK_DEPTH)
            begin
                r.status     = ST_OVER;
                mach_stopped = 1'b1;
            end
            else
            begin
                mach_stack[mach_count] = {24'd0, it.code_byte};
                mach_count++;
            end
        end
        else
        begin
            case (it.code_byte)
                OP_PUSH:
                    if (it.last_byte)
                    begin
                        r.status     = ST_MISSING;
                        mach_stopped = 1'b1;
                    end
                    else
                    begin
                        mach_await = 1'b1;
                        r.status   = ST_AWAIT;
                    end
                OP_ADD, OP_SUB, OP_MUL:
                    if (mach_count < 2)
                    begin
                        r.status     = ST_UNDER;
                        mach_stopped = 1'b1;
                    end
                    else
                    begin
                        b = mach_stack[mach_count-1];
                        a = mach_stack[mach_count-2];
                        if (it.code_byte == OP_ADD)
                            mach_stack[mach_count-2] = a + b;
                        else if (it.code_byte == OP_SUB)
                            mach_stack[mach_count-2] = a - b;
                        else
                            mach_stack[mach_count-2] = a * b;
                        mach_count--;
                    end
                OP_SHOW:
                    if (mach_count < 1)
                    begin
                        r.status     = ST_UNDER;
                        mach_stopped = 1'b1;
                    end
                    else
                    begin
                        r.print_valid = 1'b1;
                        r.print_value = mach_stack[mach_count-1];
                    end
                OP_HALT:
                begin
                    r.status     = ST_HALT;
                    mach_stopped = 1'b1;
                end
                OP_NOP:
                    ;
                default:
                begin
                    r.status     = ST_UNKNOWN;
                    mach_stopped = 1'b1;
                end
            endcase
        end
        if (it.last_byte)
            mach_stopped = 1'b1;
        r.depth = 9'(mach_count);
        return r;
    endfunction

    task automatic add_raw(logic [7:0] b, bit s, bit l);
        backlog_entry_t e;
        e.item.code_byte = b;
        e.item.start_req = s;
        e.item.last_byte = l;
        e.drain          = 1'b0;
        code_backlog.push_back(e);
        items_queued++;
    endtask

    // first byte of a program carries start_req
    task automatic add_byte(logic [7:0] b, bit l);
        add_raw(b, prog_first, l);
        prog_first = 1'b0;
    endtask

    task automatic add_drain();
        backlog_entry_t e;
        e.item  = '0;
        e.drain = 1'b1;
        code_backlog.push_back(e);
    endtask

    function automatic logic [7:0] pick_imm();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic gen_program(bit broken);
        int len;
        int live;
        int pick;
        int spot;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
        spot = broken ? $urandom_range(0, len - 1) : -1;
        live = 0;
        prog_first = 1'b1;
        for (int i = 0; i < len; i++)
        begin
            if (i == spot)
            begin
                case ($urandom_range(0, 3))
                    0:       add_byte(OP_HALT, 1'b0);
                    1:       add_byte(live < 2 ? OP_MUL : OP_SHOW, 1'b0);
                    default: add_byte(8'($urandom_range(7, 255)), 1'b0);
                endcase
            end
            pick = $urandom_range(0, 99);
            if ((live < 2) ? (pick < 70) : (pick < 35))
            begin
                add_byte(OP_PUSH, 1'b0);
                add_byte(pick_imm(), 1'b0);
                live++;
            end
            else if (pick < 70 && live >= 2)
            begin
                add_byte(8'(OP_ADD + $urandom_range(0, 2)), 1'b0);
                live--;
            end
            else if (pick < 88 && live >= 1)
                add_byte(OP_SHOW, 1'b0);
            else
                add_byte(OP_NOP, 1'b0);
        end
        if (!broken)
        begin
            case ($urandom_range(0, 3))
                0: add_byte(live >= 1 ? OP_SHOW : OP_NOP, 1'b1);
                1: add_byte(OP_HALT, 1'b1);
                2:
                begin
                    add_byte(OP_PUSH, 1'b0);
                    add_byte(pick_imm(), 1'b1);
                end
                default: add_byte(OP_NOP, 1'b1);
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: add_byte(OP_PUSH, 1'b1);
                1: add_byte(8'($urandom_range(0, 255)), 1'b1);
                default: ;  // left running, next start clears it
            endcase
        end
        repeat ($urandom_range(0, 3))
            add_raw(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    // sender
    int          send_gap = 0;
    int unsigned tx_cyc   = 0;
    bit          tx_quiet;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_valid <= 1'b0;
            code_item  <= '0;
            send_gap = 0;
        end
        else
        begin
            tx_cyc++;
            tx_quiet = tx_cyc[8] || code_backlog.size() < 100;
            if (code_valid && !code_stall)
                due_results.push_back(run_byte(code_item));
            if (!(code_valid && code_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    code_valid <= 1'b0;
                end
                else if (code_backlog.size() == 0)
                    code_valid <= 1'b0;
                else if (code_backlog[0].drain)
                begin
                    // hold off until everything sent so far is back
                    code_valid <= 1'b0;
                    if (due_results.size() == 0)
                        next_entry = code_backlog.pop_front();
                end
                else if (!tx_quiet && $urandom_range(0, 15) == 0)
                begin
                    send_gap = $urandom_range(1, 15) - 1;
                    code_valid <= 1'b0;
                end
                else
                begin
                    next_entry = code_backlog.pop_front();
                    code_valid <= 1'b1;
                    code_item  <= next_entry.item;
                end
            end
        end
    end

    // receiver and checker
    int          stall_left = 0;
    int unsigned rx_cyc     = 0;
    bit          rx_quiet;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            rx_cyc++;
            rx_quiet = rx_cyc[9] || code_backlog.size() < 100;
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result item with nothing pending");
                    mismatch_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_item.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status,
                               result_item.status);
                        mismatch_count++;
                    end
                    if (result_item.print_valid !== want.print_valid)
                    begin
                        $error("print_valid: expected %0d, actual %0d", want.print_valid,
                               result_item.print_valid);
                        mismatch_count++;
                    end
                    if (result_item.print_value !== want.print_value)
                    begin
                        $error("print_value: expected %0d, actual %0d",
                               $signed(want.print_value), $signed(result_item.print_value));
                        mismatch_count++;
                    end
                    if (result_item.depth !== want.depth)
                    begin
                        $error("depth: expected %0d, actual %0d", want.depth,
                               result_item.depth);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!rx_quiet && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        int pick;

        // directed: bytes before any start, push extremes, each opcode, each error but overflow
        add_raw(OP_NOP, 1'b0, 1'b0);
        add_raw(OP_PUSH, 1'b1, 1'b0);
        add_raw(8'hFF, 1'b0, 1'b0);
        add_raw(OP_PUSH, 1'b0, 1'b0);
        add_raw(8'h80, 1'b0, 1'b0);
        add_raw(OP_MUL, 1'b0, 1'b0);
        add_raw(OP_PUSH, 1'b0, 1'b0);
        add_raw(8'h00, 1'b0, 1'b0);
        add_raw(OP_ADD, 1'b0, 1'b0);
        add_raw(OP_PUSH, 1'b0, 1'b0);
        add_raw(8'hFF, 1'b0, 1'b0);
        add_raw(OP_SUB, 1'b0, 1'b0);
        add_raw(OP_SHOW, 1'b0, 1'b0);
        add_raw(OP_ADD, 1'b0, 1'b0);        // one entry only: underflow
        add_raw(OP_SHOW, 1'b0, 1'b0);       // ignored while stopped
        add_raw(OP_NOP, 1'b1, 1'b0);
        add_raw(OP_SHOW, 1'b0, 1'b0);       // empty stack
        add_raw(OP_HALT, 1'b1, 1'b0);
        add_raw(8'h07, 1'b1, 1'b0);
        add_raw(8'hFF, 1'b1, 1'b0);
        add_raw(OP_PUSH, 1'b1, 1'b1);       // push with no immediate left
        add_raw(OP_NOP, 1'b1, 1'b1);
        add_raw(OP_PUSH, 1'b1, 1'b0);
        add_raw(OP_PUSH, 1'b1, 1'b0);       // restart drops the pending immediate
        add_raw(8'h2A, 1'b0, 1'b1);
        add_raw(OP_SHOW, 1'b0, 1'b0);       // after the last byte
        add_drain();

        // fill the stack, then push once more than it holds
        prog_first = 1'b1;
        repeat (STACK_DEPTH)
        begin
            add_byte(OP_PUSH, 1'b0);
            add_byte(pick_imm(), 1'b0);
        end
        add_byte(OP_SHOW, 1'b0);
        add_byte(OP_MUL, 1'b0);
        add_byte(OP_SHOW, 1'b0);
        add_byte(OP_PUSH, 1'b0);
        add_byte(8'h5A, 1'b0);
        add_byte(OP_SHOW, 1'b0);
        add_byte(OP_PUSH, 1'b0);
        add_byte(8'hA5, 1'b1);
        add_drain();

        while (items_queued < 1300)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                gen_program(1'b0);
            else if (pick < 90)
                gen_program(1'b1);
            else
                repeat ($urandom_range(1, 6))
                    add_raw(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                            1'($urandom_range(0, 1)));
            if ($urandom_range(0, 29) == 0)
                add_drain();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (code_backlog.size() != 0 || code_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
hdl/bsm_pkg.sv
hdl/bsm_stack_ram.sv
hdl/bsm_exec.sv
hdl/bsm_out_buf.sv
hdl/bytecode_stack_machine_unit.sv
sim/bytecode_stack_machine_unit_tb.sv
